// ----- sv/etds_pkg.sv -----
// Shared constants, op codes and controller/datapath interface types for the trace recorder.
package etds_pkg;

    localparam int RING_DEPTH_DEF   = 256;
    localparam int MARKER_COUNT_DEF = 16;

    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_END     = 3'd1;
    localparam logic [2:0] OP_INSTANT = 3'd2;
    localparam logic [2:0] OP_QUERY   = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    typedef struct packed {
        logic acc;
        logic wr_en;
        logic wr_start;
        logic wr_latched;
        logic clr;
        logic q_init;
        logic walk;
        logic div_start;
        logic sort_init;
        logic sort_rd_i;
        logic sort_ld_v;
        logic sort_shift;
        logic sort_place;
        logic med_rd0;
        logic med_rd1;
        logic med_calc;
        logic out_ld;
        logic out_logged;
        logic out_q;
    } t_cmd;

    typedef struct packed {
        logic rec_ok;
        logic walk_done;
        logic n_zero;
        logic i_done;
        logic gt;
        logic j_one;
        logic div_done;
    } t_stat;

endpackage

// ----- sv/etds_div.sv -----
// Restoring divider, one quotient bit per cycle, for the mean duration.
module etds_div #(
    parameter int DIVIDEND_W = 41,
    parameter int DIVISOR_W  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [31:0]           o_quotient
);
    localparam int KW = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [KW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W:0]    s_shift;
    logic                  s_ge;
    logic [DIVISOR_W:0]    s_diff;

    // shift in the next dividend bit and trial-subtract
    always_comb begin
        s_shift = {r_rem, r_quo[DIVIDEND_W-1]};
        s_ge    = s_shift >= {1'b0, r_div};
        s_diff  = s_shift - {1'b0, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= KW'(DIVIDEND_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == KW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], s_ge};
            r_rem <= s_ge ? s_diff[DIVISOR_W-1:0] : s_shift[DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[31:0];
endmodule

// ----- sv/etds_ctrl.sv -----
// Sequencer for record, clear and query items, including the scratch insertion sort.
module etds_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [2:0]     i_op,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  etds_pkg::t_stat i_stat,
    output etds_pkg::t_cmd  o_cmd
);
    import etds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INST2, S_WALK, S_SORT_I, S_SORT_V, S_SORT_C, S_SORT_W,
        S_MED_A, S_MED_B, S_MED_C, S_DIVW
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   s_ready;
    logic   s_acc;

    assign s_ready     = (r_state == S_IDLE) && (!r_out_valid || !i_out_stall);
    assign s_acc       = i_in_valid && s_ready;
    assign o_in_stall  = !s_ready;
    assign o_out_valid = r_out_valid;

    // decode commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    o_cmd.acc = 1'b1;
                    case (i_op)
                        OP_START, OP_END: begin
                            o_cmd.wr_en      = i_stat.rec_ok;
                            o_cmd.wr_start   = (i_op == OP_START);
                            o_cmd.out_ld     = 1'b1;
                            o_cmd.out_logged = i_stat.rec_ok;
                        end
                        OP_INSTANT: begin
                            if (i_stat.rec_ok) begin
                                o_cmd.wr_en    = 1'b1;
                                o_cmd.wr_start = 1'b1;
                                n_state        = S_INST2;
                            end else begin
                                o_cmd.out_ld = 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            o_cmd.q_init = 1'b1;
                            n_state      = S_WALK;
                        end
                        OP_CLEAR: begin
                            o_cmd.clr    = 1'b1;
                            o_cmd.out_ld = 1'b1;
                        end
                        default: begin
                            o_cmd.out_ld = 1'b1;
                        end
                    endcase
                end
            end
            S_INST2: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.wr_latched = 1'b1;
                o_cmd.out_ld     = 1'b1;
                o_cmd.out_logged = 1'b1;
                n_state          = S_IDLE;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) begin
                    if (i_stat.n_zero) begin
                        o_cmd.out_ld = 1'b1;
                        o_cmd.out_q  = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.sort_init = 1'b1;
                        n_state         = S_SORT_I;
                    end
                end
            end
            S_SORT_I: begin
                if (i_stat.i_done) begin
                    n_state = S_MED_A;
                end else begin
                    o_cmd.sort_rd_i = 1'b1;
                    n_state         = S_SORT_V;
                end
            end
            S_SORT_V: begin
                o_cmd.sort_ld_v = 1'b1;
                n_state         = S_SORT_C;
            end
            S_SORT_C: begin
                if (i_stat.gt) begin
                    o_cmd.sort_shift = 1'b1;
                    if (i_stat.j_one) begin
                        n_state = S_SORT_W;
                    end
                end else begin
                    o_cmd.sort_place = 1'b1;
                    n_state          = S_SORT_I;
                end
            end
            S_SORT_W: begin
                o_cmd.sort_place = 1'b1;
                n_state          = S_SORT_I;
            end
            S_MED_A: begin
                o_cmd.med_rd0 = 1'b1;
                n_state       = S_MED_B;
            end
            S_MED_B: begin
                o_cmd.med_rd1 = 1'b1;
                n_state       = S_MED_C;
            end
            S_MED_C: begin
                o_cmd.med_calc = 1'b1;
                n_state        = S_DIVW;
            end
            S_DIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.out_ld = 1'b1;
                    o_cmd.out_q  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state and the result beat flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule

// ----- sv/etds_dpath.sv -----
// Trace ring, walk and pairing logic, scratch memory and the result register.
module etds_dpath #(
    parameter int RING_DEPTH   = etds_pkg::RING_DEPTH_DEF,
    parameter int MARKER_COUNT = etds_pkg::MARKER_COUNT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    input  logic [7:0]      i_marker_id,
    input  logic [31:0]     i_timestamp,
    input  etds_pkg::t_cmd  i_cmd,
    output etds_pkg::t_stat o_stat,
    output logic            o_logged,
    output logic [8:0]      o_stored_count,
    output logic            o_ring_wrapped,
    output logic [7:0]      o_pair_count,
    output logic [31:0]     o_min_duration,
    output logic [31:0]     o_max_duration,
    output logic [31:0]     o_mean_duration,
    output logic [31:0]     o_median_duration
);
    import etds_pkg::*;

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int CW   = $clog2(RING_DEPTH + 1);
    localparam int HALF = RING_DEPTH / 2;
    localparam int SAW  = $clog2(HALF);
    localparam int NW   = $clog2(HALF + 1);
    localparam int SW   = 32 + NW;
    localparam int MW   = (MARKER_COUNT > 1) ? $clog2(MARKER_COUNT) : 1;
    localparam int EW   = 33 + MW;

    // ring state
    logic [EW-1:0] tmem [RING_DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [CW-1:0] r_count, n_count;
    logic          r_wrap, n_wrap;
    logic          r_enable;
    logic [7:0]    r_l_marker;
    logic [31:0]   r_l_stamp;
    logic [EW-1:0] s_wdata;

    // walk state
    logic [7:0]    r_q_marker;
    logic [CW-1:0] r_walk_idx;
    logic [AW-1:0] r_rd_addr;
    logic          r_rd_vld;
    logic [EW-1:0] r_tdata;
    logic          s_trd;
    logic          r_open;
    logic [31:0]   r_open_stamp;
    logic [NW-1:0] r_n;
    logic [SW-1:0] r_sum;
    logic [31:0]   r_lo, r_hi;
    logic [31:0]   s_e_stamp;
    logic          s_e_start;
    logic          s_match;
    logic          s_pair;
    logic [31:0]   s_dur;

    // scratch and sort state
    logic [31:0]    smem [HALF];
    logic [31:0]    r_sdata;
    logic [NW-1:0]  r_i, r_j, s_jm1, s_jm2, s_half, s_halfm1;
    logic [31:0]    r_v, r_mlo, r_med;
    logic           s_swe, s_sre;
    logic [SAW-1:0] s_swa, s_sra;
    logic [31:0]    s_swd;
    logic [32:0]    s_msum;

    logic           s_div_done;
    logic [31:0]    s_quo;
    logic [CW+8:0]  s_cnt_ext;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_enable <= i_cfg_wr_data;
        end
    end

    // next ring pointer, fill count and wrap flag
    always_comb begin
        n_wp    = r_wp;
        n_count = r_count;
        n_wrap  = r_wrap;
        if (i_cmd.clr) begin
            n_wp    = '0;
            n_count = '0;
            n_wrap  = 1'b0;
        end else if (i_cmd.wr_en) begin
            n_wp = (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (r_count != CW'(RING_DEPTH)) begin
                n_count = r_count + 1'b1;
            end else begin
                n_wrap = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_count <= '0;
            r_wrap  <= 1'b0;
        end else begin
            r_wp    <= n_wp;
            r_count <= n_count;
            r_wrap  <= n_wrap;
        end
    end

    // latch the item for the second half of an instant
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_l_marker <= i_marker_id;
            r_l_stamp  <= i_timestamp;
        end
    end

    assign s_wdata = i_cmd.wr_latched ? {r_l_stamp, 1'b0, r_l_marker[MW-1:0]}
                                      : {i_timestamp, i_cmd.wr_start, i_marker_id[MW-1:0]};

    // trace memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            tmem[r_wp] <= s_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_trd) begin
            r_tdata <= tmem[r_rd_addr];
        end
    end

    // walk oldest to newest and pair starts with ends
    assign s_trd     = i_cmd.walk && (r_walk_idx != r_count);
    assign s_e_stamp = r_tdata[EW-1:EW-32];
    assign s_e_start = r_tdata[MW];
    assign s_match   = r_rd_vld && (r_q_marker == 8'(r_tdata[MW-1:0]));
    assign s_pair    = s_match && !s_e_start && r_open;
    assign s_dur     = s_e_stamp - r_open_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= s_trd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_init) begin
            r_q_marker <= i_marker_id;
            r_walk_idx <= '0;
            r_rd_addr  <= r_wrap ? r_wp : '0;
            r_open     <= 1'b0;
            r_n        <= '0;
            r_sum      <= '0;
            r_lo       <= '1;
            r_hi       <= '0;
        end else begin
            if (s_trd) begin
                r_walk_idx <= r_walk_idx + 1'b1;
                r_rd_addr  <= (r_rd_addr == AW'(RING_DEPTH - 1)) ? '0 : r_rd_addr + 1'b1;
            end
            if (s_match && s_e_start) begin
                r_open       <= 1'b1;
                r_open_stamp <= s_e_stamp;
            end else if (s_pair) begin
                r_open <= 1'b0;
                r_n    <= r_n + 1'b1;
                r_sum  <= r_sum + SW'(s_dur);
                if (s_dur < r_lo) begin
                    r_lo <= s_dur;
                end
                if (s_dur > r_hi) begin
                    r_hi <= s_dur;
                end
            end
        end
    end

    // scratch port selection
    assign s_jm1    = r_j - 1'b1;
    assign s_jm2    = r_j - NW'(2);
    assign s_half   = r_n >> 1;
    assign s_halfm1 = s_half - 1'b1;

    always_comb begin
        s_swe = 1'b0;
        s_swa = r_n[SAW-1:0];
        s_swd = s_dur;
        if (s_pair && (r_n < NW'(HALF))) begin
            s_swe = 1'b1;
        end else if (i_cmd.sort_shift) begin
            s_swe = 1'b1;
            s_swa = r_j[SAW-1:0];
            s_swd = r_sdata;
        end else if (i_cmd.sort_place) begin
            s_swe = 1'b1;
            s_swa = r_j[SAW-1:0];
            s_swd = r_v;
        end
    end

    always_comb begin
        s_sre = 1'b1;
        s_sra = r_i[SAW-1:0];
        if (i_cmd.sort_ld_v) begin
            s_sra = s_jm1[SAW-1:0];
        end else if (i_cmd.sort_shift) begin
            s_sra = s_jm2[SAW-1:0];
        end else if (i_cmd.med_rd0) begin
            s_sra = s_halfm1[SAW-1:0];
        end else if (i_cmd.med_rd1) begin
            s_sra = s_half[SAW-1:0];
        end else if (!i_cmd.sort_rd_i) begin
            s_sre = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_swe) begin
            smem[s_swa] <= s_swd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_sre) begin
            r_sdata <= smem[s_sra];
        end
    end

    // insertion sort indexes and median
    assign s_msum = {1'b0, r_mlo} + {1'b0, r_sdata};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_init) begin
            r_i <= NW'(1);
        end
        if (i_cmd.sort_rd_i) begin
            r_j <= r_i;
        end
        if (i_cmd.sort_ld_v) begin
            r_v <= r_sdata;
        end
        if (i_cmd.sort_shift) begin
            r_j <= s_jm1;
        end
        if (i_cmd.sort_place) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.med_rd1) begin
            r_mlo <= r_sdata;
        end
        if (i_cmd.med_calc) begin
            r_med <= r_n[0] ? r_sdata : s_msum[32:1];
        end
    end

    etds_div #(
        .DIVIDEND_W (SW),
        .DIVISOR_W  (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_n),
        .o_done     (s_div_done),
        .o_quotient (s_quo)
    );

    // status to the sequencer
    always_comb begin
        o_stat.rec_ok    = r_enable && ({1'b0, i_marker_id} < 9'(MARKER_COUNT));
        o_stat.walk_done = (r_walk_idx == r_count) && !r_rd_vld;
        o_stat.n_zero    = (r_n == '0);
        o_stat.i_done    = (r_i >= r_n);
        o_stat.gt        = (r_sdata > r_v);
        o_stat.j_one     = (r_j == NW'(1));
        o_stat.div_done  = s_div_done;
    end

    // result register
    assign s_cnt_ext = {9'd0, n_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_logged       <= i_cmd.out_logged;
            o_stored_count <= s_cnt_ext[8:0];
            o_ring_wrapped <= n_wrap;
            if (i_cmd.out_q && (r_n != '0)) begin
                o_pair_count      <= (r_n > 255) ? 8'd255 : 8'(r_n);
                o_min_duration    <= r_lo;
                o_max_duration    <= r_hi;
                o_mean_duration   <= s_quo;
                o_median_duration <= r_med;
            end else begin
                o_pair_count      <= '0;
                o_min_duration    <= '0;
                o_max_duration    <= '0;
                o_mean_duration   <= '0;
                o_median_duration <= '0;
            end
        end
    end
endmodule

// ----- sv/event_trace_duration_stats_top.sv -----
// Top level of the timestamped trace recorder with duration statistics.
//
// Input channel: i_in_valid / o_in_stall carry op, marker_id and timestamp.
// Output channel: o_out_valid / i_out_stall carry one result beat per item.
// Config: i_cfg_wr_en / i_cfg_wr_data write the record enable bit.
// Start, end, clear and unused ops: the result beat appears the cycle after
// acceptance and a new item is taken every cycle unless the output stalls.
// An instant writes a start and then an end entry via the single trace memory write port.
// A query walks the ring at one entry per cycle, then runs an insertion sort
// on the scratch memory alongside a one-bit-per-cycle divider, then forms
// the median from the middle scratch entries.
// Reset empties the ring and clears the enable bit; no clearing pass runs.
// A stalled result beat holds; the next item is still accepted if the
// stalled beat will be released in the same cycle, otherwise input stalls.
module event_trace_duration_stats_top #(
    parameter int RING_DEPTH   = etds_pkg::RING_DEPTH_DEF,
    parameter int MARKER_COUNT = etds_pkg::MARKER_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_marker_id,
    input  logic [31:0] i_timestamp,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_logged,
    output logic [8:0]  o_stored_count,
    output logic        o_ring_wrapped,
    output logic [7:0]  o_pair_count,
    output logic [31:0] o_min_duration,
    output logic [31:0] o_max_duration,
    output logic [31:0] o_mean_duration,
    output logic [31:0] o_median_duration
);
    import etds_pkg::*;

    t_cmd  s_cmd;
    t_stat s_stat;

    etds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (s_stat),
        .o_cmd       (s_cmd)
    );

    etds_dpath #(
        .RING_DEPTH   (RING_DEPTH),
        .MARKER_COUNT (MARKER_COUNT)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_marker_id       (i_marker_id),
        .i_timestamp       (i_timestamp),
        .i_cmd             (s_cmd),
        .o_stat            (s_stat),
        .o_logged          (o_logged),
        .o_stored_count    (o_stored_count),
        .o_ring_wrapped    (o_ring_wrapped),
        .o_pair_count      (o_pair_count),
        .o_min_duration    (o_min_duration),
        .o_max_duration    (o_max_duration),
        .o_mean_duration   (o_mean_duration),
        .o_median_duration (o_median_duration)
    );

    // a start or end beat produces its result on the next cycle
    a_rec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_op == OP_START || i_op == OP_END))
        |=> o_out_valid)
        else $error("start/end beat gave no result");

    // a logged beat never carries query statistics
    a_logged_no_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_logged) |-> (o_pair_count == 8'd0))
        else $error("logged beat carries pair count");

    // mean lies between min and max
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pair_count != 8'd0) |->
        (o_min_duration <= o_mean_duration && o_mean_duration <= o_max_duration))
        else $error("mean outside min/max");

    // median lies between min and max
    a_median_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pair_count != 8'd0) |->
        (o_min_duration <= o_median_duration && o_median_duration <= o_max_duration))
        else $error("median outside min/max");
endmodule
